// ===== rtl/rgc_pkg.sv =====
// shared types and constants of the real-coded gene crossover unit
`default_nettype none
package rgc_pkg;
	localparam int GeneW  = 17;
	localparam int RandW  = 16;
	localparam int IdxW   = 10;
	localparam int CutW   = 11;
	localparam int AlphaW = 10;
	localparam int OpW    = 4;
	localparam int ProdW  = 2 * GeneW;
	localparam int SqrtSteps = GeneW;
	localparam int RemW   = GeneW + 2;
	localparam int RawW   = 26;

	localparam logic [CutW-1:0]   MaxGenes   = 11'd1024;
	localparam logic [GeneW-1:0]  GeneOne    = 17'h10000;
	localparam logic [AlphaW-1:0] AlphaReset = 10'd256;

	typedef enum logic [OpW-1:0] {
		OP_AVG   = 4'd0,
		OP_GEO   = 4'd1,
		OP_ONEPT = 4'd2,
		OP_TWOPT = 4'd3,
		OP_UNIF  = 4'd4,
		OP_BLX   = 4'd5,
		OP_HEUR  = 4'd6,
		OP_LIN_A = 4'd7,
		OP_LIN_B = 4'd8,
		OP_ARITH = 4'd9
	} op_t;

	typedef enum logic [3:0] {
		K_NONE, K_COPY, K_AVG, K_GEO, K_BLX, K_HEUR, K_LIN_A, K_LIN_B, K_ARITH
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [GeneW-1:0] a;
		logic [GeneW-1:0] b;
		logic [RandW-1:0] r;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;
endpackage
`default_nettype wire

// ===== rtl/rgc_front.sv =====
// front end: takes commands, resolves the copying operators and sorts the rest
`default_nettype none
module rgc_front (
	input  wire logic                     start,
	input  wire logic [rgc_pkg::OpW-1:0]  operation,
	input  wire logic [rgc_pkg::GeneW-1:0] gene_a,
	input  wire logic [rgc_pkg::GeneW-1:0] gene_b,
	input  wire logic [rgc_pkg::RandW-1:0] random_fraction,
	input  wire logic                     random_bit,
	input  wire logic [rgc_pkg::IdxW-1:0] gene_index,
	input  wire logic [rgc_pkg::CutW-1:0] cut_first,
	input  wire logic [rgc_pkg::CutW-1:0] cut_second,
	input  wire rgc_pkg::q_stat_t         q_stat,
	output logic                          busy,
	output logic                          push,
	output rgc_pkg::item_t                item
);
	import rgc_pkg::*;

	logic [CutW-1:0] c1, c2, idx;
	logic            in_mid;

	assign c1     = (cut_first > MaxGenes) ? MaxGenes : cut_first;
	assign c2     = (cut_second > MaxGenes) ? MaxGenes : cut_second;
	assign idx    = {1'b0, gene_index};
	assign in_mid = (idx >= c1) && (idx < c2);

	assign busy = q_stat.full;
	assign push = start && !q_stat.full;

	always_comb begin
		item.a    = gene_a;
		item.b    = gene_b;
		item.r    = random_fraction;
		item.kind = K_NONE;
		unique case (operation)
			OP_AVG:   item.kind = K_AVG;
			OP_GEO:   item.kind = K_GEO;
			OP_ONEPT: begin
				item.kind = K_COPY;
				item.a    = (idx < c1) ? gene_a : gene_b;
			end
			OP_TWOPT: begin
				item.kind = K_COPY;
				item.a    = in_mid ? gene_b : gene_a;
			end
			OP_UNIF: begin
				item.kind = K_COPY;
				item.a    = random_bit ? gene_a : gene_b;
			end
			OP_BLX:   item.kind = K_BLX;
			OP_HEUR:  item.kind = K_HEUR;
			OP_LIN_A: item.kind = K_LIN_A;
			OP_LIN_B: item.kind = K_LIN_B;
			OP_ARITH: item.kind = K_ARITH;
			default:  item.kind = K_NONE;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/rgc_queue.sv =====
// two-entry queue between front and back end
`default_nettype none
module rgc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire rgc_pkg::item_t   push_item,
	input  wire logic             pop,
	output rgc_pkg::item_t        head,
	output rgc_pkg::q_stat_t      q_stat
);
	import rgc_pkg::*;

	item_t      mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign head         = mem_q[rd_q];
	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/rgc_back.sv =====
// back end: arithmetic pipeline with a one-bit-per-stage square root
`default_nettype none
module rgc_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rgc_pkg::item_t             head,
	input  wire rgc_pkg::q_stat_t           q_stat,
	input  wire logic [rgc_pkg::AlphaW-1:0] blx_alpha,
	output logic                            pop,
	output logic                            done,
	output logic [rgc_pkg::GeneW-1:0]       child_gene,
	output logic                            clamped
);
	import rgc_pkg::*;

	// stage 1: products
	logic                    vld_s1;
	kind_t                   kind_s1;
	logic [GeneW-1:0]        a_s1, b_s1;
	logic [ProdW-1:0]        prod_s1;
	logic signed [29:0]      beta_s1;
	logic signed [GeneW:0]   diff_s1;
	logic signed [34:0]      hr_s1;

	logic [11:0]             span;
	logic [27:0]             span_r;
	logic signed [GeneW:0]   diff_c, ndiff_c;

	assign pop     = !q_stat.empty;
	assign span    = 12'd256 + {1'b0, blx_alpha, 1'b0};
	assign span_r  = span * head.r;
	assign diff_c  = $signed({1'b0, head.b}) - $signed({1'b0, head.a});
	assign ndiff_c = $signed({1'b0, head.a}) - $signed({1'b0, head.b});

	always_ff @(posedge clk) begin
		kind_s1 <= head.kind;
		a_s1    <= head.a;
		b_s1    <= head.b;
		prod_s1 <= head.a * head.b;
		beta_s1 <= $signed({2'b0, span_r}) - $signed({4'b0, blx_alpha, 16'b0});
		diff_s1 <= diff_c;
		hr_s1   <= $signed({1'b0, head.r}) * ndiff_c;
	end

	// stage 2: raw result and clamp for everything but the square root
	logic                    vld_s2, geo_s2, clamp_s2;
	logic [GeneW-1:0]        child_s2;
	logic [ProdW-1:0]        rad_s2;

	logic signed [47:0]      bd;
	logic signed [49:0]      acc_blx;
	logic signed [36:0]      acc_heur, acc_arith;
	logic [GeneW:0]          sum_avg;
	logic signed [19:0]      lin_a, lin_b;
	logic signed [RawW-1:0]  raw;
	logic                    raw_clamp;
	logic [GeneW-1:0]        raw_child;

	assign bd        = beta_s1 * diff_s1;
	assign acc_blx   = $signed({9'b0, a_s1, 24'b0}) + {{2{bd[47]}}, bd} + 50'sd8388608;
	assign acc_heur  = $signed({4'b0, a_s1, 16'b0}) + {{2{hr_s1[34]}}, hr_s1} + 37'sd32768;
	assign acc_arith = $signed({4'b0, b_s1, 16'b0}) + {{2{hr_s1[34]}}, hr_s1} + 37'sd32768;
	assign sum_avg   = {1'b0, a_s1} + {1'b0, b_s1} + 18'd1;
	assign lin_a     = $signed({2'b0, a_s1, 1'b0}) + $signed({3'b0, a_s1})
	                   - $signed({3'b0, b_s1}) + 20'sd1;
	assign lin_b     = $signed({2'b0, b_s1, 1'b0}) + $signed({3'b0, b_s1})
	                   - $signed({3'b0, a_s1}) + 20'sd1;

	always_comb begin
		raw = '0;
		unique case (kind_s1)
			K_COPY:  raw = $signed({9'b0, a_s1});
			K_AVG:   raw = $signed({9'b0, sum_avg[GeneW:1]});
			K_BLX:   raw = acc_blx[49:24];
			K_HEUR:  raw = {{5{acc_heur[36]}}, acc_heur[36:16]};
			K_ARITH: raw = {{5{acc_arith[36]}}, acc_arith[36:16]};
			K_LIN_A: raw = {{7{lin_a[19]}}, lin_a[19:1]};
			K_LIN_B: raw = {{7{lin_b[19]}}, lin_b[19:1]};
			K_GEO, K_NONE: raw = '0;
			default: raw = '0;
		endcase
		if (raw < 0) begin
			raw_child = '0;
			raw_clamp = 1'b1;
		end else if (raw > $signed({9'b0, GeneOne})) begin
			raw_child = GeneOne;
			raw_clamp = 1'b1;
		end else begin
			raw_child = raw[GeneW-1:0];
			raw_clamp = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		geo_s2   <= (kind_s1 == K_GEO);
		child_s2 <= raw_child;
		clamp_s2 <= raw_clamp;
		rad_s2   <= prod_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= pop;
			vld_s2 <= vld_s1;
		end
	end

	// square root stages, two radicand bits each
	logic                vld_q   [1:SqrtSteps];
	logic                geo_q   [1:SqrtSteps];
	logic                clamp_q [1:SqrtSteps];
	logic [GeneW-1:0]    child_q [1:SqrtSteps];
	logic [ProdW-1:0]    rad_q   [1:SqrtSteps];
	logic [GeneW-1:0]    root_q  [1:SqrtSteps];
	logic [RemW-1:0]     rem_q   [1:SqrtSteps];

	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sq
		logic             vld_i, geo_i, clamp_i;
		logic [GeneW-1:0] child_i, root_i;
		logic [ProdW-1:0] rad_i;
		logic [RemW-1:0]  rem_i;
		logic [RemW+1:0]  rem_sh, trial;
		logic             fits;

		if (k == 0) begin : g_first
			assign vld_i   = vld_s2;
			assign geo_i   = geo_s2;
			assign clamp_i = clamp_s2;
			assign child_i = child_s2;
			assign rad_i   = rad_s2;
			assign root_i  = '0;
			assign rem_i   = '0;
		end else begin : g_next
			assign vld_i   = vld_q[k];
			assign geo_i   = geo_q[k];
			assign clamp_i = clamp_q[k];
			assign child_i = child_q[k];
			assign rad_i   = rad_q[k];
			assign root_i  = root_q[k];
			assign rem_i   = rem_q[k];
		end

		assign rem_sh = {rem_i, rad_i[ProdW-1-2*k -: 2]};
		assign trial  = {2'b0, root_i, 2'b01};
		assign fits   = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			geo_q[k+1]   <= geo_i;
			clamp_q[k+1] <= clamp_i;
			child_q[k+1] <= child_i;
			rad_q[k+1]   <= rad_i;
			root_q[k+1]  <= {root_i[GeneW-2:0], fits};
			rem_q[k+1]   <= fits ? RemW'(rem_sh - trial) : rem_sh[RemW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else begin
				vld_q[k+1] <= vld_i;
			end
		end
	end

	// output register
	logic             done_q, clamped_q;
	logic [GeneW-1:0] child_gene_q;
	logic             geo_big;

	assign geo_big = root_q[SqrtSteps] > GeneOne;

	always_ff @(posedge clk) begin
		if (geo_q[SqrtSteps]) begin
			child_gene_q <= geo_big ? GeneOne : root_q[SqrtSteps];
			clamped_q    <= geo_big;
		end else begin
			child_gene_q <= child_q[SqrtSteps];
			clamped_q    <= clamp_q[SqrtSteps];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_q[SqrtSteps];
		end
	end

	assign done       = done_q;
	assign child_gene = child_gene_q;
	assign clamped    = clamped_q;
endmodule
`default_nettype wire

// ===== rtl/real_gene_crossover_unit_top.sv =====
// top level of the real-coded gene crossover unit
// Takes one gene command per cycle while busy is low and returns its child gene
// on done once the command has passed the queue, stages 1 and 2, the square root
// stages and the output register; results stay in order and done cannot be
// held off. Every command passes through the pipelined 17-stage square root, so
// one transfer per cycle is sustained. busy rises only if the two-entry command
// queue fills. blx_alpha is written through cfg_valid/cfg_ready, always ready,
// and should change only while idle.
`default_nettype none
module real_gene_crossover_unit_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [rgc_pkg::OpW-1:0]    operation,
	input  wire logic [rgc_pkg::GeneW-1:0]  gene_a,
	input  wire logic [rgc_pkg::GeneW-1:0]  gene_b,
	input  wire logic [rgc_pkg::RandW-1:0]  random_fraction,
	input  wire logic                       random_bit,
	input  wire logic [rgc_pkg::IdxW-1:0]   gene_index,
	input  wire logic [rgc_pkg::CutW-1:0]   cut_first,
	input  wire logic [rgc_pkg::CutW-1:0]   cut_second,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [rgc_pkg::AlphaW-1:0] cfg_data,
	output logic                            done,
	output logic [rgc_pkg::GeneW-1:0]       child_gene,
	output logic                            clamped
);
	import rgc_pkg::*;

	logic             push, pop;
	item_t            push_item, head;
	q_stat_t          q_stat;
	logic [AlphaW-1:0] alpha_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= AlphaReset;
		end else if (cfg_valid) begin
			alpha_q <= cfg_data;
		end
	end

	rgc_front u_front (
		.start, .operation, .gene_a, .gene_b, .random_fraction, .random_bit,
		.gene_index, .cut_first, .cut_second,
		.q_stat, .busy, .push, .item(push_item)
	);

	rgc_queue u_queue (
		.clk, .arst_n, .push, .push_item, .pop, .head, .q_stat
	);

	rgc_back u_back (
		.clk, .arst_n, .head, .q_stat, .blx_alpha(alpha_q), .pop,
		.done, .child_gene, .clamped
	);
endmodule
`default_nettype wire

// ===== rtl/rgc_checker.sv =====
// port-level checks of the crossover unit and their binding
`default_nettype none
module rgc_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire logic                       busy,
	input wire logic [rgc_pkg::OpW-1:0]    operation,
	input wire logic                       done,
	input wire logic [rgc_pkg::GeneW-1:0]  child_gene,
	input wire logic                       clamped
);
	import rgc_pkg::*;

	localparam int Latency = 21;

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> child_gene <= GeneOne)
		else $error("child gene above one");

	a_clamp_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clamped) |-> (child_gene == '0 || child_gene == GeneOne))
		else $error("clamped result not at a bound");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##Latency done)
		else $error("result missing after fixed latency");

	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation > OP_ARITH) |-> ##Latency (child_gene == '0 && !clamped))
		else $error("unknown operation gave a non-zero result");
endmodule

bind real_gene_crossover_unit_top rgc_checker u_rgc_checker (
	.clk, .arst_n, .start, .busy, .operation, .done, .child_gene, .clamped
);
`default_nettype wire

// ===== test/tb.sv =====
// self-checking testbench of the real-coded gene crossover unit
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import rgc_pkg::*;

	localparam int Latency = 21;
	localparam longint CycleLimit = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [OpW-1:0] operation = '0;
	logic [GeneW-1:0] gene_a = '0, gene_b = '0;
	logic [RandW-1:0] random_fraction = '0;
	logic random_bit = 1'b0;
	logic [IdxW-1:0] gene_index = '0;
	logic [CutW-1:0] cut_first = '0, cut_second = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [AlphaW-1:0] cfg_data = '0;
	logic done;
	logic [GeneW-1:0] child_gene;
	logic clamped;

	typedef struct {
		logic [GeneW-1:0] child;
		logic clip;
	} child_t;

	child_t child_queue[$];
	logic [AlphaW-1:0] alpha_model;
	int errors = 0;
	int idle_pct = 0;
	longint cycles = 0;

	real_gene_crossover_unit_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .gene_a(gene_a), .gene_b(gene_b),
		.random_fraction(random_fraction), .random_bit(random_bit),
		.gene_index(gene_index), .cut_first(cut_first), .cut_second(cut_second),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .child_gene(child_gene), .clamped(clamped)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// floor of (v + 2^(s-1)) / 2^s
	function automatic longint round_shr(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint isqrt(longint v);
		longint res, bit_v;
		res = 0;
		bit_v = longint'(1) <<< 62;
		while (bit_v > v) bit_v = bit_v >>> 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v = v - (res + bit_v);
				res = (res >>> 1) + bit_v;
			end else res = res >>> 1;
			bit_v = bit_v >>> 2;
		end
		return res;
	endfunction

	function automatic child_t cross_child(logic [OpW-1:0] op, logic [GeneW-1:0] ga,
			logic [GeneW-1:0] gb, logic [RandW-1:0] rf, logic rb, logic [IdxW-1:0] idx,
			logic [CutW-1:0] c1i, logic [CutW-1:0] c2i);
		longint a, b, r, raw, al, beta, c1, c2;
		child_t res;
		a = ga; b = gb; r = rf; raw = 0;
		c1 = (c1i > MaxGenes) ? MaxGenes : c1i;
		c2 = (c2i > MaxGenes) ? MaxGenes : c2i;
		case (op)
			OP_AVG:   raw = round_shr(a + b, 1);
			OP_GEO:   raw = isqrt(a * b);
			OP_ONEPT: raw = (idx < c1) ? a : b;
			OP_TWOPT: raw = (idx >= c1 && idx < c2) ? b : a;
			OP_UNIF:  raw = rb ? a : b;
			OP_BLX: begin
				al = alpha_model;
				beta = -al * 65536 + (256 + 2 * al) * r;
				raw = round_shr(a * (longint'(1) <<< 24) + beta * (b - a), 24);
			end
			OP_HEUR:  raw = round_shr(a * 65536 + r * (a - b), 16);
			OP_LIN_A: raw = round_shr(3 * a - b, 1);
			OP_LIN_B: raw = round_shr(3 * b - a, 1);
			OP_ARITH: raw = round_shr(b * 65536 + r * (a - b), 16);
			default: begin
				res.child = '0; res.clip = 1'b0;
				return res;
			end
		endcase
		if (raw < 0) begin
			res.child = '0; res.clip = 1'b1;
		end else if (raw > GeneOne) begin
			res.child = GeneOne; res.clip = 1'b1;
		end else begin
			res.child = raw[GeneW-1:0]; res.clip = 1'b0;
		end
		return res;
	endfunction

	always @(posedge clk) begin
		child_t want;
		if (arst_n && done) begin
			if (child_queue.size() == 0) begin
				$display("%0t: unexpected child %h clamped %b", $time, child_gene, clamped);
				errors++;
			end else begin
				want = child_queue.pop_front();
				if (child_gene !== want.child || clamped !== want.clip) begin
					$display("%0t: expected child %h clamped %b, actual %h clamped %b",
						$time, want.child, want.clip, child_gene, clamped);
					errors++;
				end
			end
		end
	end

	task automatic send_gene(logic [OpW-1:0] op, logic [GeneW-1:0] ga,
			logic [GeneW-1:0] gb, logic [RandW-1:0] rf, logic rb, logic [IdxW-1:0] idx,
			logic [CutW-1:0] c1, logic [CutW-1:0] c2);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		operation <= op; gene_a <= ga; gene_b <= gb; random_fraction <= rf;
		random_bit <= rb; gene_index <= idx; cut_first <= c1; cut_second <= c2;
		@(posedge clk);
		while (busy) @(posedge clk);
		child_queue.push_back(cross_child(op, ga, gb, rf, rb, idx, c1, c2));
		@(negedge clk);
	endtask

	task automatic drain;
		start <= 1'b0;
		while (child_queue.size() != 0) @(negedge clk);
		repeat (Latency + 4) @(negedge clk);
	endtask

	task automatic write_alpha(logic [AlphaW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		alpha_model = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [GeneW-1:0] rand_gene();
		case ($urandom_range(9))
			0: return '0;
			1: return GeneOne;
			2: return GeneW'($urandom);
			default: return GeneW'($urandom_range(65536));
		endcase
	endfunction

	task automatic send_random(int n);
		logic [OpW-1:0] op;
		repeat (n) begin
			op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
			send_gene(op, rand_gene(), rand_gene(), RandW'($urandom), 1'($urandom),
				IdxW'($urandom),
				($urandom_range(7) == 0) ? 11'($urandom) : 11'($urandom_range(1024)),
				($urandom_range(7) == 0) ? 11'($urandom) : 11'($urandom_range(1024)));
		end
	endtask

	task automatic test_directed;
		send_gene(OP_AVG, GeneOne, GeneOne, 0, 0, 0, 0, 0);
		send_gene(OP_AVG, 1, 0, 0, 0, 0, 0, 0);
		send_gene(OP_GEO, GeneOne, GeneOne, 0, 0, 0, 0, 0);
		send_gene(OP_GEO, 17'h1FFFF, 17'h1FFFF, 0, 0, 0, 0, 0);
		send_gene(OP_ONEPT, 100, 200, 0, 0, 1023, 1024, 0);
		send_gene(OP_ONEPT, 100, 200, 0, 0, 1023, 11'h7FF, 0);
		send_gene(OP_TWOPT, 100, 200, 0, 0, 5, 5, 6);
		send_gene(OP_TWOPT, 100, 200, 0, 0, 5, 9, 2);
		send_gene(OP_TWOPT, 100, 200, 0, 0, 1023, 0, 11'h7FF);
		send_gene(OP_UNIF, 17'h1FFFF, 0, 0, 1, 0, 0, 0);
		send_gene(OP_UNIF, 17'h1FFFF, 0, 0, 0, 0, 0, 0);
		send_gene(OP_BLX, 0, GeneOne, 0, 0, 0, 0, 0);
		send_gene(OP_BLX, 0, GeneOne, 16'hFFFF, 0, 0, 0, 0);
		send_gene(OP_HEUR, GeneOne, 0, 16'hFFFF, 0, 0, 0, 0);
		send_gene(OP_HEUR, 0, GeneOne, 16'hFFFF, 0, 0, 0, 0);
		send_gene(OP_LIN_A, GeneOne, 0, 0, 0, 0, 0, 0);
		send_gene(OP_LIN_A, 0, 1, 0, 0, 0, 0, 0);
		send_gene(OP_LIN_B, 0, GeneOne, 0, 0, 0, 0, 0);
		send_gene(OP_LIN_B, 1, 0, 0, 0, 0, 0, 0);
		send_gene(OP_ARITH, GeneOne, 0, 16'h8000, 0, 0, 0, 0);
		send_gene(OP_ARITH, 17'h1FFFF, 17'h1FFFF, 16'hFFFF, 0, 0, 0, 0);
		send_gene(4'd10, GeneOne, GeneOne, 0, 0, 0, 0, 0);
		send_gene(4'd15, GeneOne, GeneOne, 0, 0, 0, 0, 0);
		drain();
	endtask

	task automatic test_random_traffic;
		int pcts[4] = '{0, 88, 0, 37};
		foreach (pcts[i]) begin
			idle_pct = pcts[i];
			send_random(300);
			drain();
		end
		idle_pct = 0;
	endtask

	task automatic test_blx_alpha;
		logic [AlphaW-1:0] alphas[5] = '{0, 512, 10'h3FF, 1, 256};
		foreach (alphas[i]) begin
			write_alpha(alphas[i]);
			idle_pct = (i % 2) ? 37 : 0;
			send_gene(OP_BLX, 0, GeneOne, 0, 0, 0, 0, 0);
			send_gene(OP_BLX, GeneOne, 0, 16'hFFFF, 0, 0, 0, 0);
			send_random(150);
			drain();
		end
		write_alpha(AlphaW'($urandom));
		send_random(50);
		drain();
	endtask

	initial begin
		alpha_model = AlphaReset;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_traffic();
		test_blx_alpha();
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ===== real_gene_crossover_unit_top.f =====
rtl/rgc_pkg.sv
rtl/rgc_front.sv
rtl/rgc_queue.sv
rtl/rgc_back.sv
rtl/real_gene_crossover_unit_top.sv
rtl/rgc_checker.sv
test/tb.sv
